>>> rtl/serc_pkg.sv
// ---------------------------------------------------------------------------
// serc_pkg
// Shared constants for the segment endpoint rectangle clipper.
// ---------------------------------------------------------------------------
package serc_pkg;

    localparam int COORD_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_X = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_Y = 2'd3;

endpackage

>>> rtl/serc_seg_if.sv
// ---------------------------------------------------------------------------
// serc_seg_if
// Segment beat channel: clip mode and the two endpoints.
// ---------------------------------------------------------------------------
interface serc_seg_if #(
    parameter int W = serc_pkg::COORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic signed [W-1:0] begin_x;
    logic signed [W-1:0] begin_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;

    modport source (output valid, mode, begin_x, begin_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, begin_x, begin_y, end_x, end_y, output ready);
endinterface

>>> rtl/serc_res_if.sv
// ---------------------------------------------------------------------------
// serc_res_if
// Result beat channel: clipped segment and clipped flag.
// ---------------------------------------------------------------------------
interface serc_res_if #(
    parameter int W = serc_pkg::COORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_begin_x;
    logic signed [W-1:0] out_begin_y;
    logic signed [W-1:0] out_end_x;
    logic signed [W-1:0] out_end_y;
    logic                clipped;

    modport source (output valid, out_begin_x, out_begin_y, out_end_x, out_end_y, clipped,
                    input ready);
    modport sink   (input valid, out_begin_x, out_begin_y, out_end_x, out_end_y, clipped,
                    output ready);
endinterface

>>> rtl/serc_side.sv
// ---------------------------------------------------------------------------
// serc_side
// One rectangle side: pipelined intersection, restoring divider, range and
// dot-product tests, endpoint move. Vertical sides swap x and y.
// ---------------------------------------------------------------------------
module serc_side #(
    parameter int W    = serc_pkg::COORD_BITS_DEF,
    parameter bit SWAP = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [4*W+1:0]      i_itm,
    input  logic signed [W-1:0] i_fix,
    input  logic signed [W-1:0] i_ra,
    input  logic signed [W-1:0] i_rb,
    output logic                o_vld,
    output logic [4*W+1:0]      o_itm
);
    import serc_pkg::*;

    localparam int IW = 4*W + 2;
    localparam int DW = W + 1;
    localparam int QB = W + 1;
    localparam int PW = 2*W;
    localparam int CW = 2*W + 1;
    localparam int NW = 2*W + 3;
    localparam int MW = 2*W + 2;
    localparam int SW = 2*W + 3;

    function automatic logic [IW-1:0] f_swap(input logic [IW-1:0] x);
        return {x[IW-1:IW-2], x[3*W-1:2*W], x[4*W-1:3*W], x[W-1:0], x[2*W-1:W]};
    endfunction

    // entry
    logic [IW-1:0]       s_itm;
    logic signed [W-1:0] s_bx, s_by, s_ex, s_ey;
    assign s_itm = SWAP ? f_swap(i_itm) : i_itm;
    assign s_bx  = s_itm[4*W-1:3*W];
    assign s_by  = s_itm[3*W-1:2*W];
    assign s_ex  = s_itm[2*W-1:W];
    assign s_ey  = s_itm[W-1:0];

    // stage A: direction and cross products
    logic                 r_vld_a, r_skp_a;
    logic [IW-1:0]        r_itm_a;
    logic signed [DW-1:0] r_a1_a, r_b1_a;
    logic signed [PW-1:0] r_p1_a, r_p2_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_a <= s_itm;
            r_a1_a  <= DW'(s_ey) - DW'(s_by);
            r_b1_a  <= DW'(s_bx) - DW'(s_ex);
            r_p1_a  <= s_ex * s_by;
            r_p2_a  <= s_bx * s_ey;
            r_skp_a <= (s_ey == s_by) || (i_ra == i_rb);
        end
    end

    // stage B: c1 and b1 * fix
    logic                 r_vld_b, r_skp_b;
    logic [IW-1:0]        r_itm_b;
    logic signed [DW-1:0] r_a1_b;
    logic signed [CW-1:0] r_c1_b, r_t_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_b <= r_itm_a;
            r_skp_b <= r_skp_a;
            r_a1_b  <= r_a1_a;
            r_c1_b  <= CW'(r_p1_a) - CW'(r_p2_a);
            r_t_b   <= r_b1_a * i_fix;
        end
    end

    // stage C: numerator
    logic                 r_vld_c, r_skp_c;
    logic [IW-1:0]        r_itm_c;
    logic signed [DW-1:0] r_a1_c;
    logic signed [NW-1:0] r_num_c;
    logic signed [NW-1:0] s_sum_c;
    assign s_sum_c = NW'(r_t_b) + NW'(r_c1_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else if (i_en) begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_c <= r_itm_b;
            r_skp_c <= r_skp_b;
            r_a1_c  <= r_a1_b;
            r_num_c <= -s_sum_c;
        end
    end

    // stage D: magnitudes, quotient sign, overflow; then one quotient bit a stage
    logic          r_vld_d [0:QB];
    logic          r_skp_d [0:QB];
    logic          r_neg_d [0:QB];
    logic [IW-1:0] r_itm_d [0:QB];
    logic [QB-1:0] r_quo_d [0:QB];
    logic [NW-1:0] r_rem_d [0:QB-1];
    logic [DW-1:0] r_dm_d  [0:QB-1];
    logic [NW-1:0] s_nm;
    logic [DW-1:0] s_dm;
    assign s_nm = r_num_c[NW-1] ? NW'(-r_num_c) : NW'(r_num_c);
    assign s_dm = r_a1_c[DW-1] ? DW'(-r_a1_c) : DW'(r_a1_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d[0] <= 1'b0;
        end else if (i_en) begin
            r_vld_d[0] <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_d[0] <= r_itm_c;
            r_skp_d[0] <= r_skp_c || ((s_nm >> QB) >= NW'(s_dm));
            r_neg_d[0] <= r_num_c[NW-1] ^ r_a1_c[DW-1];
            r_rem_d[0] <= s_nm;
            r_dm_d[0]  <= s_dm;
            r_quo_d[0] <= '0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;
        logic [NW-1:0] s_sub;
        logic          s_ge;
        assign s_sub = NW'(r_dm_d[j]) << BIT;
        assign s_ge  = r_rem_d[j] >= s_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld_d[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld_d[j+1] <= r_vld_d[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_itm_d[j+1] <= r_itm_d[j];
                r_skp_d[j+1] <= r_skp_d[j];
                r_neg_d[j+1] <= r_neg_d[j];
                r_quo_d[j+1] <= r_quo_d[j] | (QB'(s_ge) << BIT);
            end
        end

        if (j < QB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem_d[j+1] <= s_ge ? (r_rem_d[j] - s_sub) : r_rem_d[j];
                    r_dm_d[j+1]  <= r_dm_d[j];
                end
            end
        end
    end

    // stage E: signed quotient and side range test
    logic                  r_vld_e, r_skp_e;
    logic [IW-1:0]         r_itm_e;
    logic signed [W-1:0]   r_px_e;
    logic signed [QB:0]    s_qm, s_qs, s_lo, s_hi;
    assign s_qm = signed'({1'b0, r_quo_d[QB]});
    assign s_qs = r_neg_d[QB] ? -s_qm : s_qm;
    assign s_lo = (i_ra < i_rb) ? (QB+1)'(i_ra) : (QB+1)'(i_rb);
    assign s_hi = (i_ra < i_rb) ? (QB+1)'(i_rb) : (QB+1)'(i_ra);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else if (i_en) begin
            r_vld_e <= r_vld_d[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_e <= r_itm_d[QB];
            r_skp_e <= r_skp_d[QB] || (s_qs < s_lo) || (s_qs > s_hi);
            r_px_e  <= s_qs[W-1:0];
        end
    end

    // stage F: differences for the containment test
    logic                 r_vld_f, r_skp_f;
    logic [IW-1:0]        r_itm_f;
    logic signed [W-1:0]  r_px_f;
    logic signed [DW-1:0] r_dx_f, r_dy_f, r_u1_f, r_v1_f, r_u2_f, r_v2_f;
    logic signed [W-1:0]  e_bx, e_by, e_ex, e_ey;
    assign e_bx = r_itm_e[4*W-1:3*W];
    assign e_by = r_itm_e[3*W-1:2*W];
    assign e_ex = r_itm_e[2*W-1:W];
    assign e_ey = r_itm_e[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f <= 1'b0;
        end else if (i_en) begin
            r_vld_f <= r_vld_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_f <= r_itm_e;
            r_skp_f <= r_skp_e;
            r_px_f  <= r_px_e;
            r_dx_f  <= DW'(e_ex) - DW'(e_bx);
            r_dy_f  <= DW'(e_ey) - DW'(e_by);
            r_u1_f  <= DW'(r_px_e) - DW'(e_bx);
            r_v1_f  <= DW'(i_fix) - DW'(e_by);
            r_u2_f  <= DW'(r_px_e) - DW'(e_ex);
            r_v2_f  <= DW'(i_fix) - DW'(e_ey);
        end
    end

    // stage G: dot-product terms
    logic                 r_vld_g, r_skp_g;
    logic [IW-1:0]        r_itm_g;
    logic signed [W-1:0]  r_px_g;
    logic signed [MW-1:0] r_m1_g, r_m2_g, r_m3_g, r_m4_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
        end else if (i_en) begin
            r_vld_g <= r_vld_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_g <= r_itm_f;
            r_skp_g <= r_skp_f;
            r_px_g  <= r_px_f;
            r_m1_g  <= r_dx_f * r_u1_f;
            r_m2_g  <= r_dy_f * r_v1_f;
            r_m3_g  <= r_dx_f * r_u2_f;
            r_m4_g  <= r_dy_f * r_v2_f;
        end
    end

    // stage H: decide and move the chosen endpoint
    logic                 r_vld_h;
    logic [IW-1:0]        r_itm_h;
    logic signed [SW-1:0] s_d1, s_d2;
    logic                 s_take;
    logic [IW-1:0]        n_itm;
    assign s_d1   = SW'(r_m1_g) + SW'(r_m2_g);
    assign s_d2   = SW'(r_m3_g) + SW'(r_m4_g);
    assign s_take = !r_skp_g && (s_d1 >= 0) && (s_d2 <= 0);

    always_comb begin
        n_itm = r_itm_g;
        if (s_take) begin
            n_itm[IW-2] = 1'b1;
            if (r_itm_g[IW-1]) begin
                n_itm[2*W-1:0] = {r_px_g, i_fix};
            end else begin
                n_itm[4*W-1:2*W] = {r_px_g, i_fix};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_h <= 1'b0;
        end else if (i_en) begin
            r_vld_h <= r_vld_g;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_itm_h <= SWAP ? f_swap(n_itm) : n_itm;
        end
    end

    assign o_vld = r_vld_h;
    assign o_itm = r_itm_h;

endmodule

>>> rtl/segment_endpoint_rect_clip_core.sv
// ---------------------------------------------------------------------------
// segment_endpoint_rect_clip_core
// Clips one endpoint of each segment beat against a configured rectangle.
// ---------------------------------------------------------------------------
// Usage:
//   i_seg carries one segment per beat (mode, begin and end points). mode 0
//   moves the begin point, mode 1 the end point. o_res carries the clipped
//   segment and a flag set when any side moved the endpoint. One result beat
//   leaves for every segment beat, in order.
//   The rectangle is loaded through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no segment is in flight; all four registers reset to zero.
// Pipeline:
//   Sides are tried bottom, right, top, left; each side is a pipeline of
//   COORD_BITS + 9 stages (products, numerator, one quotient bit per stage,
//   range test, dot products, move). A beat may also wait in the input skid
//   while the pipeline holds. Throughput is one segment per cycle while
//   o_res is not stalled.
// Reset and stall:
//   Reset empties the pipeline and the skid register. When o_res stalls the
//   whole pipeline holds; the skid register takes one more input beat, then
//   i_seg.ready drops until the pipeline moves again.
// ---------------------------------------------------------------------------
module segment_endpoint_rect_clip_core #(
    parameter int COORD_BITS = serc_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    serc_seg_if.sink                            i_seg,
    serc_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [serc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [COORD_BITS-1:0]               i_cfg_data
);
    import serc_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int IW = 4*W + 2;

    // rectangle registers
    logic signed [W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_X: r_min_x <= i_cfg_data;
                REG_MIN_Y: r_min_y <= i_cfg_data;
                REG_MAX_X: r_max_x <= i_cfg_data;
                REG_MAX_Y: r_max_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: hold everything while a result waits unread
    logic s_en;
    logic s_out_vld;
    assign s_en = !s_out_vld || o_res.ready;

    // input skid: catch one beat while the pipeline holds
    logic          r_skv;
    logic [IW-1:0] r_sk_itm;
    logic [IW-1:0] s_in_itm;
    logic          s_ent_vld;
    logic [IW-1:0] s_ent_itm;

    assign s_in_itm    = {i_seg.mode, 1'b0, i_seg.begin_x, i_seg.begin_y,
                          i_seg.end_x, i_seg.end_y};
    assign i_seg.ready = !r_skv;
    assign s_ent_vld   = r_skv || i_seg.valid;
    assign s_ent_itm   = r_skv ? r_sk_itm : s_in_itm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skv <= 1'b0;
        end else if (s_en) begin
            r_skv <= 1'b0;
        end else if (i_seg.valid && !r_skv) begin
            r_skv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skv) begin
            r_sk_itm <= s_in_itm;
        end
    end

    // four sides in a chain: bottom, right, top, left
    logic          s_vld [0:4];
    logic [IW-1:0] s_itm [0:4];
    assign s_vld[0] = s_ent_vld;
    assign s_itm[0] = s_ent_itm;

    serc_side #(.W(W), .SWAP(1'b0)) u_bottom (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_en),
        .i_vld (s_vld[0]), .i_itm (s_itm[0]),
        .i_fix (r_min_y), .i_ra (r_min_x), .i_rb (r_max_x),
        .o_vld (s_vld[1]), .o_itm (s_itm[1])
    );

    serc_side #(.W(W), .SWAP(1'b1)) u_right (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_en),
        .i_vld (s_vld[1]), .i_itm (s_itm[1]),
        .i_fix (r_max_x), .i_ra (r_max_y), .i_rb (r_min_y),
        .o_vld (s_vld[2]), .o_itm (s_itm[2])
    );

    serc_side #(.W(W), .SWAP(1'b0)) u_top (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_en),
        .i_vld (s_vld[2]), .i_itm (s_itm[2]),
        .i_fix (r_max_y), .i_ra (r_max_x), .i_rb (r_min_x),
        .o_vld (s_vld[3]), .o_itm (s_itm[3])
    );

    serc_side #(.W(W), .SWAP(1'b1)) u_left (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s_en),
        .i_vld (s_vld[3]), .i_itm (s_itm[3]),
        .i_fix (r_min_x), .i_ra (r_min_y), .i_rb (r_max_y),
        .o_vld (s_vld[4]), .o_itm (s_itm[4])
    );

    // last side's stage register drives the result channel
    assign s_out_vld         = s_vld[4];
    assign o_res.valid       = s_out_vld;
    assign o_res.clipped     = s_itm[4][IW-2];
    assign o_res.out_begin_x = s_itm[4][4*W-1:3*W];
    assign o_res.out_begin_y = s_itm[4][3*W-1:2*W];
    assign o_res.out_end_x   = s_itm[4][2*W-1:W];
    assign o_res.out_end_y   = s_itm[4][W-1:0];

    // skid fills only while the pipeline is held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skv) |-> $past(!s_en))
        else $error("skid filled while pipeline advanced");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    // skid never holds a beat across an advance
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skv && s_en) |=> !r_skv)
        else $error("skid not drained on advance");

endmodule
